// ===== rtl/fdw_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fdw_pkg - shared types and constants for the frame dedup window filter
// Holds the stream widths, register indexes, reset values and the
// queued request and history slot layouts.
// ----------------------------------------------------------------------------
package fdw_pkg;

  // Field widths
  localparam int ID_W    = 29;
  localparam int LEN_W   = 4;
  localparam int DATA_W  = 64;
  localparam int TIME_W  = 32;
  localparam int WIN_W   = 16;
  localparam int HDEP_W  = 5;
  localparam int NBYTES  = 8;

  // Stream widths, padded to whole bytes
  localparam int IN_TDATA_W  = 136;
  localparam int OUT_TDATA_W = 8;

  // Configuration port
  localparam int CFG_ADDR_W = 1;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_ADDR_W-1:0] CFG_WINDOW = 1'b0;
  localparam logic [CFG_ADDR_W-1:0] CFG_DEPTH  = 1'b1;

  localparam logic [WIN_W-1:0]  WINDOW_RST = 16'd300;
  localparam logic [HDEP_W-1:0] DEPTH_RST  = 5'd10;

  // One request waiting between front and back
  typedef struct packed {
    logic [TIME_W-1:0] time_ms;
    logic [DATA_W-1:0] frame_data;
    logic [NBYTES-1:0] byte_en;
    logic [LEN_W-1:0]  frame_len;
    logic [ID_W-1:0]   frame_id;
  } item_t;

  // One history slot as stored in the RAM
  typedef struct packed {
    logic [TIME_W-1:0] stamp;
    logic [DATA_W-1:0] bytes;
    logic [LEN_W-1:0]  length;
    logic [ID_W-1:0]   ident;
  } slot_t;

  // Byte enables for the first len bytes, all bytes at eight and above
  function automatic logic [NBYTES-1:0] byte_enables(input logic [LEN_W-1:0] len);
    logic [NBYTES-1:0] en;
    en = '0;
    for (int b = 0; b < NBYTES; b++) begin
      en[b] = (len > LEN_W'(b));
    end
    return en;
  endfunction

endpackage

// ===== rtl/fdw_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fdw_ram - generic single write, single read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module fdw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                  clk,
  input  logic                                  wr_en,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                      wr_data,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                      rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

// ===== rtl/fdw_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fdw_front - input side of the frame dedup window filter
// Accepts frames, derives the byte enables and queues the requests
// in a two-entry queue for the search engine.
// ----------------------------------------------------------------------------
module fdw_front (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // frame_id[28:0], frame_len[32:29], frame_data[96:33], time_ms[128:97]
  input  logic [fdw_pkg::IN_TDATA_W-1:0]   in_tdata,
  output logic                             q_valid,
  output fdw_pkg::item_t                   q_item,
  input  logic                             q_pop
);
  import fdw_pkg::*;

  item_t       q_mem_r [2];
  logic        wr_ptr_r, wr_ptr_nxt;
  logic        rd_ptr_r, rd_ptr_nxt;
  logic [1:0]  count_r, count_nxt;
  logic        push;
  item_t       item_in;

  // Classify the incoming request
  always_comb begin
    item_in.frame_id   = in_tdata[28:0];
    item_in.frame_len  = in_tdata[32:29];
    item_in.frame_data = in_tdata[96:33];
    item_in.time_ms    = in_tdata[128:97];
    item_in.byte_en    = byte_enables(in_tdata[32:29]);
  end

  assign in_tready = (count_r != 2'd2);
  assign push      = in_tvalid && in_tready;
  assign q_valid   = (count_r != 2'd0);
  assign q_item    = q_mem_r[rd_ptr_r];

  // Advance pointers and count
  always_comb begin
    wr_ptr_nxt = push  ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = q_pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + 2'(push) - 2'(q_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Hold queued payload
  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[wr_ptr_r] <= item_in;
    end
  end

endmodule

// ===== rtl/fdw_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fdw_back - search engine of the frame dedup window filter
// Walks the leading history slots one per cycle, stores new frames in
// the history ring and drives the registered result.
// ----------------------------------------------------------------------------
module fdw_back #(
  parameter int HISTORY_SLOTS = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic [fdw_pkg::WIN_W-1:0]         window_ms,
  input  logic [fdw_pkg::HDEP_W-1:0]        history_depth,
  input  logic                              q_valid,
  input  fdw_pkg::item_t                    q_item,
  output logic                              q_pop,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // is_duplicate[0], zero fill [7:1]
  output logic [fdw_pkg::OUT_TDATA_W-1:0]   out_tdata
);
  import fdw_pkg::*;

  localparam int SLOT_W = (HISTORY_SLOTS > 1) ? $clog2(HISTORY_SLOTS) : 1;
  localparam int CNT_W  = $clog2(HISTORY_SLOTS + 1);
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(HISTORY_SLOTS - 1);

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_START  = 4'b0010,
    S_SCAN   = 4'b0100,
    S_FINISH = 4'b1000
  } state_t;

  state_t                state_r, state_nxt;
  logic [SLOT_W-1:0]     idx_r, idx_nxt;
  logic [SLOT_W-1:0]     wslot_r, wslot_nxt;
  logic                  dup_r, dup_nxt;
  logic [HISTORY_SLOTS-1:0] valid_r, valid_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic                  out_dup_r, out_dup_nxt;

  logic [CNT_W-1:0]      depth_cap;
  logic                  last_slot;
  logic                  slot_hit;
  logic [TIME_W-1:0]     age;
  logic [DATA_W-1:0]     diff;
  logic                  bytes_eq;
  logic                  out_free;
  logic                  ram_we;
  logic [SLOT_W-1:0]     ram_raddr;
  slot_t                 ram_wdata;
  slot_t                 ram_rdata;

  fdw_ram #(
    .WIDTH ($bits(slot_t)),
    .DEPTH (HISTORY_SLOTS)
  ) u_hist (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (wslot_r),
    .wr_data (ram_wdata),
    .rd_addr (ram_raddr),
    .rd_data (ram_rdata)
  );

  // Cap the search depth at the slot count
  always_comb begin
    if (int'(history_depth) > HISTORY_SLOTS) begin
      depth_cap = CNT_W'(HISTORY_SLOTS);
    end else begin
      depth_cap = CNT_W'(history_depth);
    end
  end

  // Compare the slot just read against the queued frame
  always_comb begin
    age  = q_item.time_ms - ram_rdata.stamp;
    diff = ram_rdata.bytes ^ q_item.frame_data;
    bytes_eq = 1'b1;
    for (int b = 0; b < NBYTES; b++) begin
      if (q_item.byte_en[b] && (diff[8*b +: 8] != 8'd0)) begin
        bytes_eq = 1'b0;
      end
    end
    slot_hit = valid_r[idx_r]
            && (age <= TIME_W'(window_ms))
            && (ram_rdata.ident == q_item.frame_id)
            && (ram_rdata.length == q_item.frame_len)
            && bytes_eq;
    last_slot = ((CNT_W'(idx_r) + CNT_W'(1)) == depth_cap);
  end

  assign out_free  = !out_valid_r || out_tready;
  assign ram_wdata = '{stamp:  q_item.time_ms,
                       bytes:  q_item.frame_data,
                       length: q_item.frame_len,
                       ident:  q_item.frame_id};

  // Sequencer
  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    wslot_nxt     = wslot_r;
    dup_nxt       = dup_r;
    valid_nxt     = valid_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_dup_nxt   = out_dup_r;
    q_pop         = 1'b0;
    ram_we        = 1'b0;
    ram_raddr     = '0;
    unique case (state_r)
      S_IDLE: begin
        dup_nxt = 1'b0;
        idx_nxt = '0;
        if (q_valid) begin
          state_nxt = (depth_cap == '0) ? S_FINISH : S_START;
        end
      end
      S_START: begin
        // issue read of slot zero
        state_nxt = S_SCAN;
      end
      S_SCAN: begin
        // prefetch the next slot while comparing this one
        ram_raddr = (idx_r == LAST_SLOT) ? '0 : idx_r + SLOT_W'(1);
        if (slot_hit) begin
          dup_nxt   = 1'b1;
          state_nxt = S_FINISH;
        end else if (last_slot) begin
          state_nxt = S_FINISH;
        end else begin
          idx_nxt = idx_r + SLOT_W'(1);
        end
      end
      S_FINISH: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_dup_nxt   = dup_r;
          q_pop         = 1'b1;
          state_nxt     = S_IDLE;
          // store a new frame and advance the ring
          if (!dup_r) begin
            ram_we            = 1'b1;
            valid_nxt[wslot_r] = 1'b1;
            wslot_nxt         = (wslot_r == LAST_SLOT) ? '0 : wslot_r + SLOT_W'(1);
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      idx_r       <= '0;
      wslot_r     <= '0;
      dup_r       <= 1'b0;
      valid_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      wslot_r     <= wslot_nxt;
      dup_r       <= dup_nxt;
      valid_r     <= valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Hold result payload
  always_ff @(posedge clk) begin
    out_dup_r <= out_dup_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {(OUT_TDATA_W-1)'(0), out_dup_r};

endmodule

// ===== rtl/frame_dedup_window_filter.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frame_dedup_window_filter - time window deduplication of bus frames
// Flags a frame as duplicate when a recent history slot holds the same
// identifier, length and leading bytes; stores frames that are new.
// ----------------------------------------------------------------------------
//  channel | dir | handshake            | payload
//  in_     | in  | in_tvalid/in_tready  | in_tdata: id, len, data, time
//  out_    | out | out_tvalid/out_tready| out_tdata: is_duplicate
//  cfg_    | in  | cfg_we               | cfg_addr, cfg_wdata
//
// Each frame searches at most depth slots, depth being history_depth capped at
// HISTORY_SLOTS (no slot is searched when depth is zero); the search reads one slot
// per cycle through the history RAM read port and stops at the first hit.
// Reset clears all slot valid bits, the write slot and the registers to
// 300 ms and depth 10. A two-entry queue takes frames while a search runs;
// a stalled result holds the search engine in its final state.
// ----------------------------------------------------------------------------
module frame_dedup_window_filter #(
  parameter int HISTORY_SLOTS = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // frame_id[28:0], frame_len[32:29], frame_data[96:33], time_ms[128:97]
  input  logic [fdw_pkg::IN_TDATA_W-1:0]    in_tdata,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // is_duplicate[0], zero fill [7:1]
  output logic [fdw_pkg::OUT_TDATA_W-1:0]   out_tdata,
  input  logic                              cfg_we,
  input  logic [fdw_pkg::CFG_ADDR_W-1:0]    cfg_addr,
  input  logic [fdw_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
  import fdw_pkg::*;

  logic [WIN_W-1:0]  window_r, window_nxt;
  logic [HDEP_W-1:0] depth_r, depth_nxt;
  logic              q_valid;
  logic              q_pop;
  item_t             q_item;

  // Configuration writes
  always_comb begin
    window_nxt = window_r;
    depth_nxt  = depth_r;
    if (cfg_we) begin
      unique case (cfg_addr)
        CFG_WINDOW: window_nxt = cfg_wdata[WIN_W-1:0];
        CFG_DEPTH:  depth_nxt  = cfg_wdata[HDEP_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_r <= WINDOW_RST;
      depth_r  <= DEPTH_RST;
    end else begin
      window_r <= window_nxt;
      depth_r  <= depth_nxt;
    end
  end

  fdw_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop)
  );

  fdw_back #(
    .HISTORY_SLOTS (HISTORY_SLOTS)
  ) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .window_ms     (window_r),
    .history_depth (depth_r),
    .q_valid       (q_valid),
    .q_item        (q_item),
    .q_pop         (q_pop),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .out_tdata     (out_tdata)
  );

endmodule
